// ----- sv/hyperloglog_register_update_assert.svh -----
// Assertion macros for the HyperLogLog register update block.
`ifndef HYPERLOGLOG_REGISTER_UPDATE_ASSERT_SVH
`define HYPERLOGLOG_REGISTER_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, muted while reset is asserted.
`define HLLRU_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check that also holds through reset.
`define HLLRU_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define HLLRU_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define HLLRU_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ----- sv/hllru_pkg.sv -----
// Shared types and constants of the HyperLogLog register update block.
package hllru_pkg;

    localparam int MAX_INDEX_BITS = 12;
    localparam int HASH_W    = 64;
    localparam int IDX_W     = MAX_INDEX_BITS;
    localparam int REG_W     = 6;
    localparam int BIN_W     = 6;
    localparam int HIST_BINS = 64;
    localparam int COUNT_W   = MAX_INDEX_BITS + 1;
    localparam int CFG_W     = 4;
    localparam int MIN_P     = 2;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

    localparam logic [1:0] FUNC_ADD      = 2'd0;
    localparam logic [1:0] FUNC_MERGE    = 2'd1;
    localparam logic [1:0] FUNC_READ_REG = 2'd2;
    localparam logic [1:0] FUNC_READ_BIN = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_DEC,
        ST_INC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic restart;
        logic clear;
        logic capture;
        logic look;
        logic eval;
        logic dec;
        logic inc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic raise;
    } sts_t;

endpackage

// ----- sv/hllru_ctrl.sv -----
// Sequencer for clearing, item processing and the result register handshake.
`include "hyperloglog_register_update_assert.svh"

module hllru_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  hllru_pkg::sts_t sts,
    output hllru_pkg::cmd_t cmd
);

    hllru_pkg::state_t state_reg;
    hllru_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    // A config write in the same cycle wins; the item waits for the clear pass.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == hllru_pkg::ST_IDLE) && !cfg_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        if (cfg_valid)
        begin
            state_next = hllru_pkg::ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                hllru_pkg::ST_CLEAR: if (sts.clr_last) state_next = hllru_pkg::ST_IDLE;
                hllru_pkg::ST_IDLE:  if (in_valid) state_next = hllru_pkg::ST_LOOK;
                hllru_pkg::ST_LOOK:  state_next = hllru_pkg::ST_EVAL;
                hllru_pkg::ST_EVAL:  state_next = sts.raise ? hllru_pkg::ST_DEC
                                                            : hllru_pkg::ST_DONE;
                hllru_pkg::ST_DEC:   state_next = hllru_pkg::ST_INC;
                hllru_pkg::ST_INC:   state_next = hllru_pkg::ST_DONE;
                hllru_pkg::ST_DONE:  if (out_free) state_next = hllru_pkg::ST_IDLE;
                default:             state_next = hllru_pkg::ST_CLEAR;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.restart  = cfg_valid;
        cmd.clear    = (state_reg == hllru_pkg::ST_CLEAR) && !cfg_valid;
        cmd.capture  = in_ready && in_valid;
        cmd.look     = (state_reg == hllru_pkg::ST_LOOK);
        cmd.eval     = (state_reg == hllru_pkg::ST_EVAL);
        cmd.dec      = (state_reg == hllru_pkg::ST_DEC);
        cmd.inc      = (state_reg == hllru_pkg::ST_INC);
        cmd.load_out = (state_reg == hllru_pkg::ST_DONE) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hllru_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `HLLRU_ASSERT(a_load_into_free_slot, clk, rst_n,
                  cmd.load_out |-> (!out_valid_reg || out_ready),
                  "result loaded over a waiting item")
    `HLLRU_ASSERT(a_raise_goes_to_dec, clk, rst_n,
                  (state_reg == hllru_pkg::ST_EVAL && sts.raise && !cfg_valid)
                  |=> (state_reg == hllru_pkg::ST_DEC),
                  "raised register skipped histogram update")
    `HLLRU_ASSERT(a_dec_then_inc, clk, rst_n,
                  (state_reg == hllru_pkg::ST_DEC && !cfg_valid)
                  |=> (state_reg == hllru_pkg::ST_INC),
                  "histogram decrement without increment")
    `HLLRU_ASSERT_ALWAYS(a_cfg_starts_clear, clk,
                         cfg_valid |=> (state_reg == hllru_pkg::ST_CLEAR),
                         "config write did not start a clear pass")

endmodule

// ----- sv/hllru_datapath.sv -----
// Register memory, histogram memory, rank logic and result registers.
module hllru_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hllru_pkg::cmd_t               cmd,
    output hllru_pkg::sts_t               sts,
    input  logic [hllru_pkg::CFG_W-1:0]   cfg_data,
    input  logic [1:0]                    func,
    input  logic [hllru_pkg::HASH_W-1:0]  hash,
    input  logic [hllru_pkg::IDX_W-1:0]   index,
    input  logic [hllru_pkg::REG_W-1:0]   value,
    output logic                          changed,
    output logic [hllru_pkg::REG_W-1:0]   reg_value,
    output logic [hllru_pkg::COUNT_W-1:0] bin_count,
    output logic                          index_error
);

    localparam int MAX_INDEX_BITS = hllru_pkg::MAX_INDEX_BITS;
    localparam int ADDR_W = MAX_INDEX_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = MAX_INDEX_BITS + 1;
    localparam int P_W    = $clog2(MAX_INDEX_BITS + 1);
    localparam int CLR_W  = (ADDR_W > hllru_pkg::BIN_W) ? ADDR_W : hllru_pkg::BIN_W;
    localparam logic [hllru_pkg::HASH_W-1:0] ONES = '1;

    // Leading zeros of a 64-bit word: per-byte counts, then the first busy byte.
    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [3:0] lz8 [8];
        logic [7:0] nz;
        logic [7:0] b;
        logic       found;
        logic [6:0] n;
        for (int g = 0; g < 8; g++)
        begin
            b      = x[63 - 8 * g -: 8];
            nz[g]  = |b;
            lz8[g] = 4'd8;
            for (int k = 0; k < 8; k++)
            begin
                if (b[k]) lz8[g] = 4'(7 - k);
            end
        end
        n     = 7'd64;
        found = 1'b0;
        for (int g = 0; g < 8; g++)
        begin
            if (!found && nz[g])
            begin
                n     = 7'(8 * g) + 7'(lz8[g]);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic [hllru_pkg::REG_W-1:0] reg_mem  [DEPTH];
    logic [CNT_W-1:0]            hist_mem [hllru_pkg::HIST_BINS];

    logic [hllru_pkg::CFG_W-1:0]   cfg_reg;
    logic [CLR_W-1:0]              clr_cnt_reg;
    logic [1:0]                    func_reg;
    logic [hllru_pkg::HASH_W-1:0]  hash_reg;
    logic [hllru_pkg::IDX_W-1:0]   index_reg;
    logic [hllru_pkg::REG_W-1:0]   value_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic [hllru_pkg::REG_W-1:0]   cand_reg;
    logic                          err_reg;
    logic [hllru_pkg::REG_W-1:0]   old_reg;
    logic [hllru_pkg::REG_W-1:0]   reg_rdata_reg;
    logic [CNT_W-1:0]              hist_rdata_reg;
    logic                          res_changed_reg;
    logic [hllru_pkg::REG_W-1:0]   res_value_reg;
    logic [hllru_pkg::COUNT_W-1:0] res_count_reg;
    logic                          res_err_reg;
    logic                          out_changed_reg;
    logic [hllru_pkg::REG_W-1:0]   out_value_reg;
    logic [hllru_pkg::COUNT_W-1:0] out_count_reg;
    logic                          out_err_reg;

    logic [P_W-1:0]                p_eff;
    logic [7:0]                    cfg8;
    logic [ADDR_W-1:0]             addr_look;
    logic [hllru_pkg::REG_W-1:0]   rank_look;
    logic                          err_look;
    logic                          raise;
    logic                          reg_we;
    logic [ADDR_W-1:0]             reg_waddr;
    logic [hllru_pkg::REG_W-1:0]   reg_wdata;
    logic                          hist_we;
    logic [hllru_pkg::BIN_W-1:0]   hist_waddr;
    logic [CNT_W-1:0]              hist_wdata;
    logic [hllru_pkg::BIN_W-1:0]   hist_raddr;
    logic                          clr_in_regs;
    logic                          clr_in_hist;

    // Index width in use, clamped to the supported range.
    assign cfg8 = 8'(cfg_reg);
    always_comb
    begin
        priority if (cfg8 < 8'(hllru_pkg::MIN_P))
            p_eff = P_W'(hllru_pkg::MIN_P);
        else if (cfg8 > 8'(MAX_INDEX_BITS))
            p_eff = P_W'(MAX_INDEX_BITS);
        else
            p_eff = P_W'(cfg_reg);
    end

    // Rank = leading zeros below the index field, plus one; the masked top bits
    // count as zeros, so p is taken off again. All-zero remainder gives 65 - p.
    assign rank_look = hllru_pkg::REG_W'(clz64(hash_reg & (ONES >> p_eff))
                                         + 7'd1 - 7'(p_eff));
    assign addr_look = (func_reg == hllru_pkg::FUNC_ADD)
                       ? ADDR_W'(hash_reg >> (7'd64 - 7'(p_eff)))
                       : ADDR_W'(index_reg);
    assign err_look  = ((func_reg == hllru_pkg::FUNC_MERGE) ||
                        (func_reg == hllru_pkg::FUNC_READ_REG)) &&
                       ((index_reg >> p_eff) != '0);

    assign raise = ((func_reg == hllru_pkg::FUNC_ADD) ||
                    ((func_reg == hllru_pkg::FUNC_MERGE) && !err_reg)) &&
                   (cand_reg > reg_rdata_reg);

    assign sts.raise    = raise;
    assign sts.clr_last = &clr_cnt_reg;

    assign clr_in_regs = (clr_cnt_reg >> ADDR_W) == '0;
    assign clr_in_hist = (clr_cnt_reg >> hllru_pkg::BIN_W) == '0;

    always_comb
    begin
        reg_we    = 1'b0;
        reg_waddr = addr_reg;
        reg_wdata = cand_reg;
        if (cmd.clear)
        begin
            reg_we    = clr_in_regs;
            reg_waddr = ADDR_W'(clr_cnt_reg);
            reg_wdata = '0;
        end
        else if (cmd.eval)
        begin
            reg_we = raise;
        end
    end

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = cand_reg;
        hist_wdata = hist_rdata_reg + CNT_W'(1);
        if (cmd.clear)
        begin
            hist_we    = clr_in_hist;
            hist_waddr = hllru_pkg::BIN_W'(clr_cnt_reg);
            hist_wdata = (hllru_pkg::BIN_W'(clr_cnt_reg) == '0)
                         ? (CNT_W'(1) << p_eff) : '0;
        end
        else if (cmd.dec)
        begin
            hist_we    = 1'b1;
            hist_waddr = old_reg;
            hist_wdata = (hist_rdata_reg != '0) ? hist_rdata_reg - CNT_W'(1) : '0;
        end
        else if (cmd.inc)
        begin
            hist_we = 1'b1;
        end
    end

    always_comb
    begin
        priority if (cmd.eval)
            hist_raddr = reg_rdata_reg;
        else if (cmd.dec)
            hist_raddr = cand_reg;
        else
            hist_raddr = value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            reg_mem[reg_waddr] <= reg_wdata;
        end
        reg_rdata_reg <= reg_mem[addr_look];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= hllru_pkg::INDEX_BITS_RESET;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                cfg_reg     <= cfg_data;
                clr_cnt_reg <= '0;
            end
            else if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            hash_reg  <= hash;
            index_reg <= index;
            value_reg <= value;
        end
        if (cmd.look)
        begin
            addr_reg <= addr_look;
            cand_reg <= (func_reg == hllru_pkg::FUNC_ADD) ? rank_look : value_reg;
            err_reg  <= err_look;
        end
        if (cmd.eval)
        begin
            old_reg         <= reg_rdata_reg;
            res_changed_reg <= raise;
            res_err_reg     <= err_reg;
            if (err_reg || (func_reg == hllru_pkg::FUNC_READ_BIN))
                res_value_reg <= '0;
            else
                res_value_reg <= raise ? cand_reg : reg_rdata_reg;
            res_count_reg <= (func_reg == hllru_pkg::FUNC_READ_BIN)
                             ? hllru_pkg::COUNT_W'(hist_rdata_reg) : '0;
        end
        if (cmd.load_out)
        begin
            out_changed_reg <= res_changed_reg;
            out_value_reg   <= res_value_reg;
            out_count_reg   <= res_count_reg;
            out_err_reg     <= res_err_reg;
        end
    end

    assign changed     = out_changed_reg;
    assign reg_value   = out_value_reg;
    assign bin_count   = out_count_reg;
    assign index_error = out_err_reg;

endmodule

// ----- sv/hyperloglog_register_update.sv -----
// Top level of the HyperLogLog register update block.
//
// HyperLogLog sketch store: 2^p six-bit rank registers (p = index_bits, clamped to
// 2..MAX_INDEX_BITS) plus a 64-bin histogram of register values. func 0 adds a
// precomputed 64-bit hash: the top p bits pick the register, the rank is the
// leading-zero count of the rest plus one (65 - p when the rest is all zero),
// and a larger rank replaces the register and moves one count between bins.
// func 1 merges value into register index, func 2 reads register index, func 3
// reads histogram bin value. Each item gives exactly one result; an index of
// 2^p or more on merge or register read flags index_error and changes nothing.
// An item passes through accept, lookup, evaluate and result steps when no
// register rises, and also through a decrement and an increment step when one
// does: the read-modify-write of the old and new bins in the histogram memory;
// the next item is taken while a result waits in the output register. After
// reset and after every index_bits write, a clear pass sweeps both memories
// with in_ready low; cfg_ready is always high and a write is only expected
// while the block is idle.
module hyperloglog_register_update
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write: index_bits
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hllru_pkg::CFG_W-1:0]   cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [hllru_pkg::HASH_W-1:0]  hash,
    input  logic [hllru_pkg::IDX_W-1:0]   index,
    input  logic [hllru_pkg::REG_W-1:0]   value,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          changed,
    output logic [hllru_pkg::REG_W-1:0]   reg_value,
    output logic [hllru_pkg::COUNT_W-1:0] bin_count,
    output logic                          index_error
);

    hllru_pkg::cmd_t cmd;
    hllru_pkg::sts_t sts;

    // Config writes always land; they restart the clear pass.
    assign cfg_ready = 1'b1;

    hllru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hllru_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_data    (cfg_data),
        .func        (func),
        .hash        (hash),
        .index       (index),
        .value       (value),
        .changed     (changed),
        .reg_value   (reg_value),
        .bin_count   (bin_count),
        .index_error (index_error)
    );

endmodule
